[sv/fdem_pkg.sv]
// Shared constants for the forward-difference edge map: register indexes, reset frame size and result queue sizes.
package fdem_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    localparam cfg_index_t CFG_IMAGE_WIDTH  = 2'd0;
    localparam cfg_index_t CFG_IMAGE_HEIGHT = 2'd1;

    // Frame size after reset (capped at the build maximum)
    localparam int DEFAULT_DIM = 1024;

    // Result queue: one request can raise up to three results
    localparam int MAX_RESULTS = 3;
    localparam int RES_DEPTH   = 4;
    localparam int RES_PTR_W   = 2;
    localparam int RES_CNT_W   = 3;

endpackage

[sv/forward_difference_edge_map.sv]
// Results are queued when their pixel request is accepted and are offered from the queue head.
// Throughput, while out_stall is low: one pixel per cycle outside the last row; there a pixel raises
//   at most two results (three at the row end), and the single output port sets the pace at one a cycle.
// The line store read ports are registered and follow the column counter every cycle.
// Reset: counters, left pixel and result queue clear and the frame size returns to 1024 x 1024;
//   the line store is not cleared and needs no clearing pass, each entry is written a row before it is read.
module forward_difference_edge_map
    import fdem_pkg::*;
#(
    parameter int PIXEL_BITS = 8,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    localparam int COL_W  = $clog2(MAX_WIDTH),
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
    localparam int WREG_W = $clog2(MAX_WIDTH + 1),
    localparam int HREG_W = $clog2(MAX_HEIGHT + 1),
    localparam int CFG_W  = (WREG_W > HREG_W) ? WREG_W : HREG_W
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_write_en,
    input  cfg_index_t             cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    // pixel requests
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [PIXEL_BITS-1:0]  pixel,
    // result requests
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [PIXEL_BITS:0]    edge_value,
    output logic [ROW_W-1:0]       out_row,
    output logic [COL_W-1:0]       out_col,
    output logic                   last_of_input,
    output logic                   end_of_frame
);

    localparam int EV_W   = PIXEL_BITS + 1;
    localparam int WIDTH_RESET  = (MAX_WIDTH < DEFAULT_DIM) ? MAX_WIDTH : DEFAULT_DIM;
    localparam int HEIGHT_RESET = (MAX_HEIGHT < DEFAULT_DIM) ? MAX_HEIGHT : DEFAULT_DIM;

    typedef struct packed {
        logic [EV_W-1:0]  edge_value;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last_of_input;
        logic             end_of_frame;
    } res_entry_t;

    function automatic logic [PIXEL_BITS-1:0] abs_diff(input logic [PIXEL_BITS-1:0] a,
                                                       input logic [PIXEL_BITS-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Control state
    logic [WREG_W-1:0]     width_reg,  width_next;
    logic [HREG_W-1:0]     height_reg, height_next;
    logic [COL_W-1:0]      col_reg,    col_next;
    logic [ROW_W-1:0]      row_reg,    row_next;
    logic [PIXEL_BITS-1:0] left_reg,   left_next;
    logic [RES_PTR_W-1:0]  head_reg,   head_next;
    logic [RES_PTR_W-1:0]  tail_reg,   tail_next;
    logic [RES_CNT_W-1:0]  count_reg,  count_next;

    // Line store and its registered read ports
    logic [PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] above_reg;
    logic [PIXEL_BITS-1:0] above_right_reg;
    logic [COL_W-1:0]      rd_addr_a;
    logic [COL_W-1:0]      rd_addr_b;

    // Result queue storage
    res_entry_t            res_mem [RES_DEPTH];

    logic                  in_accept;
    logic                  out_accept;
    logic                  last_col;
    logic                  last_row;
    logic                  restart;
    logic [WREG_W-1:0]     cfg_width;
    logic [HREG_W-1:0]     cfg_height;
    logic [PIXEL_BITS-1:0] d_down;
    logic [PIXEL_BITS-1:0] d_right;
    res_entry_t            cand       [MAX_RESULTS];
    logic [MAX_RESULTS-1:0] cand_valid;
    logic [RES_PTR_W-1:0]  cand_pos   [MAX_RESULTS];
    logic [RES_CNT_W-1:0]  n_push;

    // Handshakes; stall while the queue cannot take a full burst of results
    assign in_stall   = (count_reg > RES_CNT_W'(RES_DEPTH - MAX_RESULTS));
    assign in_accept  = in_valid && !in_stall;
    assign out_valid  = (count_reg != '0);
    assign out_accept = out_valid && !out_stall;

    // Frame position flags
    assign last_col = ((WREG_W'(col_reg) + WREG_W'(1)) >= width_reg);
    assign last_row = ((HREG_W'(row_reg) + HREG_W'(1)) >= height_reg);

    // Written sizes: zero reads as one, anything over the maximum saturates
    always_comb
    begin
        cfg_width  = cfg_data[WREG_W-1:0];
        cfg_height = cfg_data[HREG_W-1:0];
        if (cfg_width == '0)
        begin
            cfg_width = WREG_W'(1);
        end
        else if (cfg_width > WREG_W'(MAX_WIDTH))
        begin
            cfg_width = WREG_W'(MAX_WIDTH);
        end
        if (cfg_height == '0)
        begin
            cfg_height = HREG_W'(1);
        end
        else if (cfg_height > HREG_W'(MAX_HEIGHT))
        begin
            cfg_height = HREG_W'(MAX_HEIGHT);
        end
    end

    // Register writes and raster counters
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        left_next   = left_reg;
        restart     = 1'b0;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:
                begin
                    width_next = cfg_width;
                    restart    = 1'b1;
                end
                CFG_IMAGE_HEIGHT:
                begin
                    height_next = cfg_height;
                    restart     = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
            if (restart)
            begin
                col_next  = '0;
                row_next  = '0;
                left_next = '0;
            end
        end
        else if (in_accept)
        begin
            if (last_col)
            begin
                col_next  = '0;
                left_next = '0;
                row_next  = last_row ? '0 : (row_reg + ROW_W'(1));
            end
            else
            begin
                col_next  = col_reg + COL_W'(1);
                left_next = pixel;
            end
        end
    end

    // Candidate results: the pixel above, the left neighbour, and the pixel itself at the end of the frame
    assign d_down  = abs_diff(pixel, above_reg);
    assign d_right = last_col ? '0 : abs_diff(above_right_reg, above_reg);

    always_comb
    begin
        cand_valid[0]          = (row_reg != '0);
        cand[0].edge_value     = EV_W'(d_down) + EV_W'(d_right);
        cand[0].row            = row_reg - ROW_W'(1);
        cand[0].col            = col_reg;
        cand[0].end_of_frame   = 1'b0;

        cand_valid[1]          = last_row && (col_reg != '0);
        cand[1].edge_value     = EV_W'(abs_diff(pixel, left_reg));
        cand[1].row            = row_reg;
        cand[1].col            = col_reg - COL_W'(1);
        cand[1].end_of_frame   = 1'b0;

        cand_valid[2]          = last_row && last_col;
        cand[2].edge_value     = '0;
        cand[2].row            = row_reg;
        cand[2].col            = col_reg;
        cand[2].end_of_frame   = 1'b1;

        // the last valid candidate closes the request
        cand[0].last_of_input  = cand_valid[0] && !cand_valid[1] && !cand_valid[2];
        cand[1].last_of_input  = cand_valid[1] && !cand_valid[2];
        cand[2].last_of_input  = cand_valid[2];

        // packed slot of each candidate behind the queue tail
        cand_pos[0] = '0;
        cand_pos[1] = RES_PTR_W'(cand_valid[0]);
        cand_pos[2] = RES_PTR_W'(cand_valid[0]) + RES_PTR_W'(cand_valid[1]);

        n_push = in_accept ? (RES_CNT_W'(cand_valid[0]) + RES_CNT_W'(cand_valid[1])
                              + RES_CNT_W'(cand_valid[2])) : '0;
    end

    // Queue pointers
    always_comb
    begin
        tail_next  = tail_reg + RES_PTR_W'(n_push);
        head_next  = out_accept ? (head_reg + RES_PTR_W'(1)) : head_reg;
        count_next = count_reg + n_push - RES_CNT_W'(out_accept);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WREG_W'(WIDTH_RESET);
            height_reg <= HREG_W'(HEIGHT_RESET);
            col_reg    <= '0;
            row_reg    <= '0;
            left_reg   <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            left_reg   <= left_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
        end
    end

    // Line store: write the new pixel, read the next column pair with write bypass
    assign rd_addr_a = col_next;
    assign rd_addr_b = col_next + COL_W'(1);

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            line_mem[col_reg] <= pixel;
        end
        if (in_accept && (col_reg == rd_addr_a))
        begin
            above_reg <= pixel;
        end
        else
        begin
            above_reg <= line_mem[rd_addr_a];
        end
        if (in_accept && (col_reg == rd_addr_b))
        begin
            above_right_reg <= pixel;
        end
        else
        begin
            above_right_reg <= line_mem[rd_addr_b];
        end
    end

    // Result queue entries
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            if (in_accept && cand_valid[k])
            begin
                res_mem[tail_reg + cand_pos[k]] <= cand[k];
            end
        end
    end

    // Queue head drives the outputs
    assign edge_value    = res_mem[head_reg].edge_value;
    assign out_row       = res_mem[head_reg].row;
    assign out_col       = res_mem[head_reg].col;
    assign last_of_input = res_mem[head_reg].last_of_input;
    assign end_of_frame  = res_mem[head_reg].end_of_frame;

endmodule

[sv/fdem_checker.sv]
// Port-level checks for the forward-difference edge map, bound to the top level.
module fdem_checker
#(
    parameter int PIXEL_BITS = 8,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [PIXEL_BITS:0]    edge_value,
    input  logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] out_row,
    input  logic [$clog2(MAX_WIDTH)-1:0] out_col,
    input  logic                   last_of_input,
    input  logic                   end_of_frame
);

    // A stalled result request holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(edge_value) && $stable(out_row)
                                   && $stable(out_col) && $stable(last_of_input)
                                   && $stable(end_of_frame))
        else $error("result changed while stalled");

    // The frame's last pixel has no right or lower neighbour: zero, and it closes its request
    a_eof_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_frame |-> last_of_input && (edge_value == '0))
        else $error("end of frame result malformed");

    // All results of one pixel are queued together, so a group never runs dry midway
    a_group_whole: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_input |=> out_valid)
        else $error("result group broken up");

endmodule

bind forward_difference_edge_map fdem_checker #(
    .PIXEL_BITS (PIXEL_BITS),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
) u_fdem_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .edge_value    (edge_value),
    .out_row       (out_row),
    .out_col       (out_col),
    .last_of_input (last_of_input),
    .end_of_frame  (end_of_frame)
);

[sim/testbench.sv]
// Self-checking testbench for the forward-difference edge map: directed and random frames.
module testbench;
    import fdem_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Indexes outside the register map; writes to them must be ignored
    localparam cfg_index_t CFG_SPARE_2 = 2'd2;
    localparam cfg_index_t CFG_SPARE_3 = 2'd3;
    localparam int LINE_MAX  = 1024;
    localparam int ROWS_MAX  = 4096;
    localparam int IDLE_PCT  = 14;
    localparam int LONG_HOLD = 150;

    typedef struct {
        logic [8:0]  edge_val;
        logic [11:0] row;
        logic [9:0]  col;
        logic        last_flag;
        logic        eof_flag;
    } edge_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write_en;
    cfg_index_t  cfg_index;
    logic [12:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  pixel;
    logic        out_valid;
    logic        out_stall;
    logic [8:0]  edge_value;
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic        last_of_input;
    logic        end_of_frame;

    // Predictor state: frame size, raster position, previous row and left neighbour
    int unsigned  frame_w = DEFAULT_DIM;
    int unsigned  frame_h = DEFAULT_DIM;
    int unsigned  col_cnt = 0;
    int unsigned  row_cnt = 0;
    logic [7:0]   left_px = '0;
    logic [7:0]   line_mem [0:LINE_MAX-1];

    edge_result_t pending_edges[$];
    int           error_count = 0;
    bit           calm = 1'b0;
    int           hold_request = 0;

    forward_difference_edge_map dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel        (pixel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .edge_value   (edge_value),
        .out_row      (out_row),
        .out_col      (out_col),
        .last_of_input(last_of_input),
        .end_of_frame (end_of_frame)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned abs_diff(input int unsigned a, input int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic edge_result_t make_result(input int unsigned v, input int unsigned r,
                                                 input int unsigned c, input bit eof);
        edge_result_t res;
        res.edge_val  = 9'(v);
        res.row       = 12'(r);
        res.col       = 10'(c);
        res.last_flag = 1'b0;
        res.eof_flag  = eof;
        return res;
    endfunction

    // Work out the results raised by one accepted pixel and advance the raster position
    task automatic predict_edges(input logic [7:0] p);
        edge_result_t res[$];
        int unsigned  c;
        int unsigned  r;
        int unsigned  v;
        bit           last_col;
        bit           last_row;
        c = col_cnt;
        r = row_cnt;
        last_col = (c + 1 >= frame_w);
        last_row = (r + 1 >= frame_h);
        // pixel above is now complete: its lower neighbour has arrived
        if (r > 0)
        begin
            v = abs_diff(p, line_mem[c]);
            if (!last_col)
                v += abs_diff(line_mem[c+1], line_mem[c]);
            res.push_back(make_result(v, r - 1, c, 1'b0));
        end
        line_mem[c] = p;
        // bottom row has no lower neighbour: left pixel completes now, row end gives 0
        if (last_row)
        begin
            if (c > 0)
                res.push_back(make_result(abs_diff(p, left_px), r, c - 1, 1'b0));
            if (last_col)
                res.push_back(make_result(0, r, c, 1'b1));
        end
        if (res.size() > 0)
            res[res.size()-1].last_flag = 1'b1;
        foreach (res[i])
            pending_edges.push_back(res[i]);
        left_px = p;
        if (last_col)
        begin
            col_cnt = 0;
            left_px = '0;
            row_cnt = last_row ? 0 : r + 1;
        end
        else
            col_cnt = c + 1;
    endtask

    // Mirror of a register write in the predictor
    task automatic apply_register(input cfg_index_t idx, input logic [12:0] value);
        int unsigned v;
        if (idx == CFG_IMAGE_WIDTH)
        begin
            v = value[10:0];
            frame_w = (v == 0) ? 1 : (v > LINE_MAX) ? LINE_MAX : v;
        end
        else if (idx == CFG_IMAGE_HEIGHT)
        begin
            v = value[12:0];
            frame_h = (v == 0) ? 1 : (v > ROWS_MAX) ? ROWS_MAX : v;
        end
        else
            return;
        col_cnt = 0;
        row_cnt = 0;
        left_px = '0;
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [12:0] value);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge clk);
        apply_register(idx, value);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one pixel request, idling first now and then, and wait for acceptance
    task automatic send_pixel(input logic [7:0] p);
        if (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= p;
        do
            @(posedge clk);
        while (in_stall);
        predict_edges(p);
    endtask

    // Stop the pixel stream and wait until the block has nothing left to deliver
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_edges.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic set_frame(input int unsigned w, input int unsigned h);
        settle();
        write_register(CFG_IMAGE_WIDTH, 13'(w));
        write_register(CFG_IMAGE_HEIGHT, 13'(h));
    endtask

    task automatic send_frame(input logic [7:0] pix[]);
        foreach (pix[i])
            send_pixel(pix[i]);
    endtask

    // Reset size is 1024 x 1024: the top row raises nothing
    task automatic test_reset_size();
        send_frame('{8'h00, 8'hFF, 8'h55, 8'hAA});
        settle();
    endtask

    // Zero sizes clamp to one, high data bits are masked, spare indexes leave the frame alone
    task automatic test_registers();
        write_register(CFG_IMAGE_WIDTH, 13'd0);
        write_register(CFG_IMAGE_HEIGHT, 13'd0);
        send_frame('{8'h00, 8'hFF});
        set_frame(0, 2);
        write_register(CFG_IMAGE_WIDTH, 13'h1803);
        send_frame('{8'hFF, 8'h00});
        settle();
        write_register(CFG_SPARE_2, 13'h1FFF);
        write_register(CFG_SPARE_3, 13'h0001);
        send_frame('{8'h80, 8'h7F, 8'h01, 8'hFE});
        settle();
    endtask

    // Single column, single row and a two by two frame
    task automatic test_small_shapes();
        set_frame(1, 3);
        send_frame('{8'hFF, 8'h00, 8'hFF});
        set_frame(4, 1);
        send_frame('{8'h00, 8'hFF, 8'h01, 8'h00});
        set_frame(2, 2);
        send_frame('{8'hFF, 8'h00, 8'h00, 8'hFF});
        settle();
    endtask

    // Random small frames: mostly whole frames, some cut short, some running into the next
    task automatic test_random_frames();
        int unsigned sent;
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned k;
        sent = 0;
        k = 0;
        while (sent < 100)
        begin
            w = ($urandom_range(9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 6);
            h = $urandom_range(1, 5);
            set_frame(w, h);
            calm = (k == 3);
            n = w * h;
            case ($urandom_range(5))
                0:       n = $urandom_range(1, n);
                1:       n = 2 * n;
                default: ;
            endcase
            // keep the total close to the item budget
            if (sent + n > 110)
                n = 110 - sent;
            for (int i = 0; i < n; i++)
            begin
                // an ignored write halfway through must not restart the frame
                if (i == n / 2 && $urandom_range(5) == 0)
                begin
                    settle();
                    write_register(CFG_SPARE_3, 13'($urandom_range(8191)));
                end
                send_pixel(rand_pixel());
            end
            sent += n;
            k++;
        end
        calm = 1'b0;
        settle();
    endtask

    // Long receiver hold fills the block; then the sender waits for every result mid-frame
    task automatic test_backpressure();
        set_frame(7, 9);
        calm = 1'b1;
        hold_request = LONG_HOLD;
        for (int i = 0; i < 30; i++)
            send_pixel(rand_pixel());
        calm = 1'b0;
        settle();
        for (int i = 30; i < 63; i++)
            send_pixel(rand_pixel());
        settle();
    endtask

    // Saturating writes: start of a full-width single row, then of a full-height single column
    task automatic test_full_size();
        settle();
        write_register(CFG_IMAGE_WIDTH, 13'h07FF);
        write_register(CFG_IMAGE_HEIGHT, 13'd1);
        for (int i = 0; i < 12; i++)
            send_pixel(rand_pixel());
        settle();
        write_register(CFG_IMAGE_WIDTH, 13'd1);
        write_register(CFG_IMAGE_HEIGHT, 13'h1FFF);
        for (int i = 0; i < 12; i++)
            send_pixel(rand_pixel());
        settle();
    endtask

    // Result side stall: random, long hold on request, none during calm stretches
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (calm)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Compare each delivered result with the oldest prediction
    always @(posedge clk)
    begin
        edge_result_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_edges.size() == 0)
            begin
                $error("unexpected result: row %0d col %0d edge_value %0d",
                       out_row, out_col, edge_value);
                error_count++;
            end
            else
            begin
                exp_res = pending_edges.pop_front();
                if (edge_value !== exp_res.edge_val)
                begin
                    $error("edge_value: expected %0d, actual %0d", exp_res.edge_val, edge_value);
                    error_count++;
                end
                if (out_row !== exp_res.row)
                begin
                    $error("out_row: expected %0d, actual %0d", exp_res.row, out_row);
                    error_count++;
                end
                if (out_col !== exp_res.col)
                begin
                    $error("out_col: expected %0d, actual %0d", exp_res.col, out_col);
                    error_count++;
                end
                if (last_of_input !== exp_res.last_flag)
                begin
                    $error("last_of_input: expected %0d, actual %0d",
                           exp_res.last_flag, last_of_input);
                    error_count++;
                end
                if (end_of_frame !== exp_res.eof_flag)
                begin
                    $error("end_of_frame: expected %0d, actual %0d",
                           exp_res.eof_flag, end_of_frame);
                    error_count++;
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = CFG_IMAGE_WIDTH;
        cfg_data     = '0;
        in_valid     = 1'b0;
        pixel        = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_size();
        test_registers();
        test_small_shapes();
        test_random_frames();
        test_backpressure();
        test_full_size();
        repeat (8) @(posedge clk);
        if (error_count == 0 && pending_edges.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
